// ----- rtl/core/fic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_pkg
// Shared constants and types of the framed int8 convolver.
// ----------------------------------------------------------------------------
package fic_pkg;

  localparam int unsigned MaxSum      = 64;
  localparam int unsigned HeaderBytes = 3;
  localparam int unsigned StoreDepth  = 64;
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned MaxTotal    = HeaderBytes + MaxSum;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StRun,
    StDrain
  } cnv_state_e;

endpackage

// ----- rtl/core/framed_int8_convolver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_int8_convolver
// Collects a length-prefixed frame of int8 samples and kernel taps in two
// synchronous RAMs, then computes the full linear convolution with a single
// multiply-accumulate unit, emitting one wrapped 8-bit result per output.
// ----------------------------------------------------------------------------
// Frame bytes are taken while busy is low; a bad total byte yields its error
// result on the next cycle. After the closing byte the header is checked in
// StCheck, then every product term (len_x*len_h in all) passes through the
// RAM read, multiply and accumulate registers; busy stays high until the last result.
// The receiver cannot stall; results are one-cycle strobes.
// Reset clears the control state and counters; the RAMs are not cleared.

module framed_int8_convolver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [7:0]        rx_byte_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output logic signed [7:0] result_value_o,
  output logic              last_o,
  output logic              error_o
);

  localparam int unsigned AW = fic_pkg::AddrW;

  fic_pkg::cnv_state_e state_q, state_d;

  logic [6:0] byte_count_q, byte_count_d;
  logic [6:0] frame_total_q, frame_total_d;
  logic [6:0] first_q, first_d;
  logic [6:0] second_q, second_d;

  logic [AW-1:0] n_q, n_d;
  logic [AW-1:0] k_q, k_d;

  logic [7:0] sig_mem [fic_pkg::StoreDepth];
  logic [7:0] ker_mem [fic_pkg::StoreDepth];

  logic          sig_we, ker_we;
  logic [AW-1:0] sig_waddr, ker_waddr;
  logic          rd_en;
  logic [AW-1:0] sig_raddr, ker_raddr;
  logic [7:0]    sig_rdata_q, ker_rdata_q;

  logic valid1_q, last_k1_q, last_n1_q;
  logic valid2_q, last_k2_q, last_n2_q;
  logic signed [15:0] prod;
  logic [7:0] prod_q;
  logic [7:0] acc_q;
  logic [7:0] acc_sum;

  logic       accept;
  logic [7:0] sat_b;
  logic [6:0] pos, hp;
  logic       hdr_err;
  logic [7:0] len_sum;
  logic       frame_ok;
  logic [AW-1:0] k_hi, k_lo_next;
  logic [6:0]    n_next;
  logic          last_k, last_n;

  logic result_valid_q, last_q, error_q;
  logic [7:0] result_value_q;
  logic emit_err;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != fic_pkg::StIdle);

  assign sat_b   = (rx_byte_i > 8'd127) ? 8'd127 : rx_byte_i;
  assign pos     = byte_count_q - 7'(fic_pkg::HeaderBytes);
  assign hp      = pos - first_q;
  assign hdr_err = (rx_byte_i == 8'd0) || (rx_byte_i > 8'(fic_pkg::MaxTotal));

  assign len_sum  = {1'b0, first_q} + {1'b0, second_q};
  assign frame_ok = (first_q != 7'd0) && (second_q != 7'd0) &&
                    (len_sum <= 8'(fic_pkg::MaxSum)) &&
                    ({1'b0, frame_total_q} == len_sum + 8'(fic_pkg::HeaderBytes));

  assign k_hi      = ({1'b0, n_q} < first_q) ? n_q : AW'(first_q - 7'd1);
  assign n_next    = {1'b0, n_q} + 7'd1;
  assign k_lo_next = (n_next >= second_q) ? AW'(n_next - second_q + 7'd1) : '0;
  assign last_k    = (k_q == k_hi);
  assign last_n    = ({2'b0, n_q} == len_sum - 8'd2);

  always_comb begin
    state_d       = state_q;
    byte_count_d  = byte_count_q;
    frame_total_d = frame_total_q;
    first_d       = first_q;
    second_d      = second_q;
    n_d           = n_q;
    k_d           = k_q;
    sig_we        = 1'b0;
    ker_we        = 1'b0;
    sig_waddr     = pos[AW-1:0];
    ker_waddr     = hp[AW-1:0];
    rd_en         = 1'b0;
    sig_raddr     = k_q;
    ker_raddr     = n_q - k_q;
    emit_err      = 1'b0;
    unique case (state_q)
      fic_pkg::StIdle: begin
        if (accept) begin
          byte_count_d = byte_count_q + 7'd1;
          priority if (byte_count_q == 7'd0) begin
            first_d       = '0;
            second_d      = '0;
            frame_total_d = sat_b[6:0];
          end else if (byte_count_q == 7'd1) begin
            first_d = sat_b[6:0];
          end else if (byte_count_q == 7'd2) begin
            second_d = sat_b[6:0];
          end else if (pos < first_q) begin
            sig_we = 1'b1;
          end else if (hp < second_q) begin
            ker_we = 1'b1;
          end
          if (byte_count_q == 7'd0 && hdr_err) begin
            emit_err     = 1'b1;
            byte_count_d = '0;
          end else if (byte_count_d == frame_total_d) begin
            byte_count_d = '0;
            state_d      = fic_pkg::StCheck;
          end
        end
      end
      fic_pkg::StCheck: begin
        n_d = '0;
        k_d = '0;
        if (frame_ok) begin
          state_d = fic_pkg::StRun;
        end else begin
          emit_err = 1'b1;
          state_d  = fic_pkg::StIdle;
        end
      end
      fic_pkg::StRun: begin
        rd_en = 1'b1;
        if (!last_k) begin
          k_d = k_q + AW'(1);
        end else if (last_n) begin
          state_d = fic_pkg::StDrain;
        end else begin
          n_d = n_next[AW-1:0];
          k_d = k_lo_next;
        end
      end
      fic_pkg::StDrain: begin
        if (valid2_q && last_k2_q && last_n2_q) begin
          state_d = fic_pkg::StIdle;
        end
      end
      default: state_d = fic_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fic_pkg::StIdle;
      byte_count_q  <= '0;
      frame_total_q <= '0;
      first_q       <= '0;
      second_q      <= '0;
      n_q           <= '0;
      k_q           <= '0;
    end else begin
      state_q       <= state_d;
      byte_count_q  <= byte_count_d;
      frame_total_q <= frame_total_d;
      first_q       <= first_d;
      second_q      <= second_d;
      n_q           <= n_d;
      k_q           <= k_d;
    end
  end

  // sample and tap RAMs with registered read data
  always_ff @(posedge clk_i) begin
    if (sig_we) begin
      sig_mem[sig_waddr] <= rx_byte_i;
    end
    if (rd_en) begin
      sig_rdata_q <= sig_mem[sig_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ker_we) begin
      ker_mem[ker_waddr] <= rx_byte_i;
    end
    if (rd_en) begin
      ker_rdata_q <= ker_mem[ker_raddr];
    end
  end

  // MAC pipeline: read, multiply, accumulate
  assign prod    = $signed(sig_rdata_q) * $signed(ker_rdata_q);
  assign acc_sum = acc_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      valid1_q <= rd_en;
      valid2_q <= valid1_q;
      if (valid2_q) begin
        acc_q <= last_k2_q ? 8'd0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_k1_q <= last_k;
    last_n1_q <= last_n;
    last_k2_q <= last_k1_q;
    last_n2_q <= last_n1_q;
    prod_q    <= prod[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
      result_value_q <= '0;
      last_q         <= 1'b0;
      error_q        <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      priority if (emit_err) begin
        result_valid_q <= 1'b1;
        result_value_q <= '0;
        last_q         <= 1'b1;
        error_q        <= 1'b1;
      end else if (valid2_q && last_k2_q) begin
        result_valid_q <= 1'b1;
        result_value_q <= acc_sum;
        last_q         <= last_n2_q;
        error_q        <= 1'b0;
      end
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_value_o = $signed(result_value_q);
  assign last_o         = last_q;
  assign error_o        = error_q;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && error_o |-> last_o && (result_value_o == 8'sd0))
    else $error("error result not final or nonzero");

  a_mac_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid2_q |-> (state_q == fic_pkg::StRun) || (state_q == fic_pkg::StDrain))
    else $error("MAC pipeline active outside a run");

  a_no_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sig_we || ker_we) |-> (state_q == fic_pkg::StIdle))
    else $error("RAM write while convolving");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("busy after final result");

  a_run_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fic_pkg::StRun) |=> valid1_q)
    else $error("run cycle issued no read");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed int8 convolver. Frame bytes go in
// through the start/busy command port. A behavioral predictor tracks the
// frame header and sample stores and computes the expected wrapped
// convolution or reject. Each strobed result is compared with the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       err;
  } sample_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic [7:0]        rx_byte_i;
  logic              busy_o;
  logic              result_valid_o;
  logic signed [7:0] result_value_o;
  logic              last_o;
  logic              error_o;

  sample_t           pending_samples[$];
  int                sample_errors = 0;
  int                bytes_sent = 0;
  bit                idling_on = 1'b0;

  logic [6:0]        rx_count = '0;
  logic [6:0]        frame_len = '0;
  int                len_x = 0;
  int                len_h = 0;
  logic signed [7:0] sig_mem[fic_pkg::StoreDepth];
  logic signed [7:0] ker_mem[fic_pkg::StoreDepth];

  framed_int8_convolver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .rx_byte_i     (rx_byte_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_value_o(result_value_o),
    .last_o        (last_o),
    .error_o       (error_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic reject_frame();
    pending_samples.push_back('{value: 8'h00, last: 1'b1, err: 1'b1});
    rx_count = '0;
  endtask

  task automatic close_frame();
    int acc;
    int count;
    if (len_x < 1 || len_h < 1 || len_x + len_h > fic_pkg::MaxSum ||
        int'(frame_len) != fic_pkg::HeaderBytes + len_x + len_h) begin
      reject_frame();
      return;
    end
    count = len_x + len_h - 1;
    for (int n = 0; n < count; n++) begin
      acc = 0;
      for (int k = 0; k <= n; k++) begin
        if (k < len_x && n - k < len_h) begin
          acc = acc + int'(sig_mem[k]) * int'(ker_mem[n - k]);
        end
      end
      pending_samples.push_back('{value: acc[7:0], last: (n + 1 == count), err: 1'b0});
    end
    rx_count = '0;
  endtask

  // frame parser and convolution predictor
  task automatic absorb_frame_byte(input logic [7:0] b);
    int pos;
    int hp;
    if (rx_count == 0) begin
      len_x = 0;
      len_h = 0;
      if (b == 0 || b > fic_pkg::MaxTotal) begin
        frame_len = (b > 127) ? 7'd127 : b[6:0];
        reject_frame();
        return;
      end
      frame_len = b[6:0];
    end else if (rx_count == 1) begin
      len_x = (b > 127) ? 127 : int'(b);
    end else if (rx_count == 2) begin
      len_h = (b > 127) ? 127 : int'(b);
    end else begin
      pos = int'(rx_count) - fic_pkg::HeaderBytes;
      if (pos < len_x) begin
        if (pos < fic_pkg::StoreDepth) sig_mem[pos] = b;
      end else begin
        hp = pos - len_x;
        if (hp < len_h && hp < fic_pkg::StoreDepth) ker_mem[hp] = b;
      end
    end
    rx_count = rx_count + 7'd1;
    if (rx_count == frame_len) close_frame();
  endtask

  // start is left high; the next caller lowers it when it idles
  task automatic send_frame_byte(input logic [7:0] b);
    start_i   <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    absorb_frame_byte(b);
    bytes_sent++;
  endtask

  task automatic idle_cycles(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_frame_byte(b);
    if (idling_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 17));
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic test_bad_totals();
    put_byte(8'd0);
    put_byte(8'(fic_pkg::MaxTotal + 1));
    put_byte(8'hFF);
    drain_results();
  endtask

  task automatic test_short_totals();
    put_byte(8'd1);
    put_byte(8'd2);
    put_byte(8'd7);
    drain_results();
  endtask

  task automatic test_minimal_frame();
    put_byte(8'd5);
    put_byte(8'd1);
    put_byte(8'd1);
    put_byte(8'h80);
    put_byte(8'h80);
    drain_results();
  endtask

  task automatic test_extreme_samples();
    put_byte(8'd6);
    put_byte(8'd2);
    put_byte(8'd1);
    put_byte(8'h7F);
    put_byte(8'h80);
    put_byte(8'h7F);
    drain_results();
  endtask

  // total too long for the lengths: the extra byte is ignored, then reject
  task automatic test_header_mismatch();
    put_byte(8'd6);
    put_byte(8'd1);
    put_byte(8'd1);
    put_byte(8'h55);
    put_byte(8'hAA);
    put_byte(8'h33);
    put_byte(8'd4);
    put_byte(8'd0);
    put_byte(8'd1);
    put_byte(8'h01);
    drain_results();
  endtask

  task automatic send_random_frame();
    int kind;
    int lx;
    int lh;
    int total;
    int sum;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      if ($urandom_range(0, 99) < 6) begin
        sum = $urandom_range(40, fic_pkg::MaxSum);
        lx  = $urandom_range(1, sum - 1);
        lh  = sum - lx;
      end else begin
        lx = $urandom_range(1, 6);
        lh = $urandom_range(1, 6);
      end
      total = fic_pkg::HeaderBytes + lx + lh;
    end else if (kind < 82) begin
      put_byte(($urandom_range(0, 1) == 0) ? 8'd0 :
               8'($urandom_range(fic_pkg::MaxTotal + 1, 255)));
      return;
    end else if (kind < 92) begin
      total = $urandom_range(1, fic_pkg::MaxTotal);
      lx    = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
      lh    = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
    end else begin
      lx    = $urandom_range(0, 8);
      lh    = $urandom_range(0, 8);
      total = fic_pkg::HeaderBytes + lx + lh + (($urandom_range(0, 1) == 0) ? -1 : 1);
      if (total < 1) total = 1;
    end
    for (int i = 0; i < total; i++) begin
      if (i == 0) put_byte(8'(total));
      else if (i == 1) put_byte(8'(lx));
      else if (i == 2) put_byte(8'(lh));
      else put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_frames();
    idling_on = 1'b1;
    while (bytes_sent < 270) send_random_frame();
    drain_results();
    while (bytes_sent < 300) send_random_frame();
    idling_on = 1'b0;
    while (bytes_sent < 360) send_random_frame();
  endtask

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_samples.size() == 0) begin
        sample_errors++;
        if (sample_errors <= 10)
          $display("unexpected result: value=%0d last=%0b error=%0b",
                   result_value_o, last_o, error_o);
      end else begin
        want = pending_samples.pop_front();
        if (want !== {result_value_o, last_o, error_o}) begin
          sample_errors++;
          if (sample_errors <= 10)
            $display({"mismatch: expected value=%0d last=%0b error=%0b, ",
                      "got value=%0d last=%0b error=%0b"},
                     $signed(want.value), want.last, want.err,
                     result_value_o, last_o, error_o);
        end
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    rx_byte_i = 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_totals();
    test_short_totals();
    test_minimal_frame();
    test_extreme_samples();
    test_header_mismatch();
    idling_on = 1'b1;
    test_random_frames();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (sample_errors == 0) begin
      $display("framed_int8_convolver verification clean");
    end else begin
      $display("framed_int8_convolver verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("framed_int8_convolver verification failed");
    $finish;
  end

endmodule
